// File: sv/tkts_pkg.sv
`default_nettype none
package tkts_pkg;

  localparam logic [7:0] KEY_ESC     = 8'h1b;
  localparam logic [7:0] KEY_PREFIX  = 8'he0;
  localparam logic [7:0] KEY_NUL     = 8'h00;
  localparam logic [7:0] KEY_BRACKET = 8'h5b;
  localparam logic [7:0] KEY_O       = 8'h4f;
  localparam logic [7:0] KEY_P       = 8'h50;
  localparam logic [7:0] KEY_TILDE   = 8'h7e;
  localparam logic [7:0] KEY_A       = 8'h41;
  localparam logic [7:0] KEY_D       = 8'h44;
  localparam logic [7:0] KEY_0       = 8'h30;
  localparam logic [7:0] KEY_9       = 8'h39;

  localparam logic [6:0] PARAM_MAX = 7'd100;

  localparam logic [7:0] FKEY_BASE_LO  = 8'h3b;
  localparam logic [7:0] FKEY_BASE_MID = 8'h40;
  localparam logic [7:0] FKEY_BASE_HI  = 8'h85;

  localparam logic [7:0] SCAN_UP    = 8'h48;
  localparam logic [7:0] SCAN_DOWN  = 8'h50;
  localparam logic [7:0] SCAN_RIGHT = 8'h4d;
  localparam logic [7:0] SCAN_LEFT  = 8'h4b;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_BRACKET = 3'd2,
    PH_ESC_O   = 3'd3,
    PH_DIGITS  = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [6:0] param;
    logic       prefix_pending;
  } dec_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] scan;
    logic [6:0] ascii;
  } dec_result_t;

  localparam logic [7:0] SCAN_ROM [128] = '{
    8'h00, 8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22,
    8'h0e, 8'h0f, 8'h1c, 8'h25, 8'h26, 8'h1c, 8'h31, 8'h18,
    8'h19, 8'h10, 8'h13, 8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11,
    8'h2d, 8'h15, 8'h2c, 8'h01, 8'h2b, 8'h1b, 8'h07, 8'h0c,
    8'h39, 8'h02, 8'h28, 8'h04, 8'h05, 8'h06, 8'h08, 8'h28,
    8'h0a, 8'h0b, 8'h09, 8'h0d, 8'h33, 8'h0c, 8'h34, 8'h35,
    8'h0b, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
    8'h09, 8'h0a, 8'h27, 8'h27, 8'h33, 8'h0d, 8'h34, 8'h35,
    8'h03, 8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22,
    8'h23, 8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18,
    8'h19, 8'h10, 8'h13, 8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11,
    8'h2d, 8'h15, 8'h2c, 8'h1a, 8'h2b, 8'h1b, 8'h07, 8'h0c,
    8'h29, 8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22,
    8'h23, 8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18,
    8'h19, 8'h10, 8'h13, 8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11,
    8'h2d, 8'h15, 8'h2c, 8'h1a, 8'h2b, 8'h1b, 8'h29, 8'h0e
  };

endpackage
`default_nettype wire

// File: sv/tkts_decode.sv
`default_nettype none
module tkts_decode (
  input  wire logic                 prefix_mode,
  input  wire logic [7:0]           key_byte,
  input  wire tkts_pkg::dec_state_t state,
  output tkts_pkg::dec_state_t      state_next,
  output tkts_pkg::dec_result_t     result
);

  logic       is_digit;
  logic [6:0] digit;
  logic [7:0] plain_scan;
  logic [10:0] acc;
  logic [6:0] acc_sat;
  logic [7:0] fkey_scan;
  logic       fkey_hit;
  logic [7:0] arrow_scan;
  logic       handled;

  assign is_digit   = (key_byte >= tkts_pkg::KEY_0) && (key_byte <= tkts_pkg::KEY_9);
  assign digit      = {3'd0, key_byte[3:0]};
  assign plain_scan = key_byte[7] ? 8'd0 : tkts_pkg::SCAN_ROM[key_byte[6:0]];

  // param * 10 + digit, param stays at or below 100
  assign acc     = {1'b0, state.param, 3'd0} + {3'd0, state.param, 1'b0} + {4'd0, digit};
  assign acc_sat = (acc > {4'd0, tkts_pkg::PARAM_MAX}) ? tkts_pkg::PARAM_MAX : acc[6:0];

  always_comb begin
    fkey_hit  = 1'b1;
    fkey_scan = 8'd0;
    if (state.param >= 7'd11 && state.param <= 7'd15) begin
      fkey_scan = tkts_pkg::FKEY_BASE_LO + {1'b0, state.param - 7'd11};
    end else if (state.param >= 7'd17 && state.param <= 7'd21) begin
      fkey_scan = tkts_pkg::FKEY_BASE_MID + {1'b0, state.param - 7'd17};
    end else if (state.param >= 7'd23 && state.param <= 7'd24) begin
      fkey_scan = tkts_pkg::FKEY_BASE_HI + {1'b0, state.param - 7'd23};
    end else begin
      fkey_hit = 1'b0;
    end
  end

  // letters A..D carry low bits 1, 2, 3, 0
  always_comb begin
    case (key_byte[1:0])
      2'd1:    arrow_scan = tkts_pkg::SCAN_UP;
      2'd2:    arrow_scan = tkts_pkg::SCAN_DOWN;
      2'd3:    arrow_scan = tkts_pkg::SCAN_RIGHT;
      default: arrow_scan = tkts_pkg::SCAN_LEFT;
    endcase
  end

  always_comb begin
    state_next   = state;
    result.emit  = 1'b0;
    result.scan  = plain_scan;
    result.ascii = key_byte[6:0];
    handled      = 1'b0;

    if (prefix_mode) begin
      if (state.prefix_pending) begin
        state_next.prefix_pending = 1'b0;
        result.emit  = (key_byte != tkts_pkg::KEY_NUL);
        result.scan  = key_byte;
        result.ascii = 7'd0;
      end else if (key_byte == tkts_pkg::KEY_PREFIX || key_byte == tkts_pkg::KEY_NUL) begin
        state_next.prefix_pending = 1'b1;
      end else begin
        result.emit = (plain_scan != 8'd0);
      end
    end else begin
      case (state.phase)
        tkts_pkg::PH_ESC: begin
          if (key_byte == tkts_pkg::KEY_BRACKET) begin
            state_next.phase = tkts_pkg::PH_BRACKET;
            handled = 1'b1;
          end else if (key_byte == tkts_pkg::KEY_O) begin
            state_next.phase = tkts_pkg::PH_ESC_O;
            handled = 1'b1;
          end
        end
        tkts_pkg::PH_BRACKET: begin
          if (key_byte >= tkts_pkg::KEY_A && key_byte <= tkts_pkg::KEY_D) begin
            state_next.phase = tkts_pkg::PH_IDLE;
            result.emit  = 1'b1;
            result.scan  = arrow_scan;
            result.ascii = 7'd0;
            handled = 1'b1;
          end else if (is_digit) begin
            state_next.phase = tkts_pkg::PH_DIGITS;
            state_next.param = digit;
            handled = 1'b1;
          end
        end
        tkts_pkg::PH_ESC_O: begin
          if (key_byte == tkts_pkg::KEY_P) begin
            state_next.phase = tkts_pkg::PH_IDLE;
            handled = 1'b1;
          end else if (is_digit) begin
            state_next.phase = tkts_pkg::PH_DIGITS;
            state_next.param = digit;
            handled = 1'b1;
          end
        end
        tkts_pkg::PH_DIGITS: begin
          if (is_digit) begin
            state_next.param = acc_sat;
            handled = 1'b1;
          end else if (key_byte == tkts_pkg::KEY_TILDE) begin
            state_next.phase = tkts_pkg::PH_IDLE;
            result.emit  = fkey_hit;
            result.scan  = fkey_scan;
            result.ascii = 7'd0;
            handled = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // unmatched or idle: drop any prefix, decode this byte by itself
      if (!handled) begin
        if (key_byte == tkts_pkg::KEY_ESC) begin
          state_next.phase = tkts_pkg::PH_ESC;
          state_next.param = 7'd0;
        end else begin
          state_next.phase = tkts_pkg::PH_IDLE;
          result.emit = (plain_scan != 8'd0);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/terminal_key_to_scancode_core.sv
// Translates a host keyboard byte stream into PC (scan code, ASCII) pairs. One byte
// is taken per clock; each request is registered in the stage register, decoded there
// by a one-step parser against the escape state, and its pair, if any, is written to
// the output register when the stage advances. The one-step parser update sets the rate
// of one byte per cycle, sustained while out_ready is high. Bytes that complete no key
// give no result. Writing prefix_mode (only while idle) clears the parser state.
`default_nettype none
module terminal_key_to_scancode_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic       cfg_write_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] key_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      scan_code,
  output logic [6:0]      ascii_code
);

  logic                  prefix_mode;
  logic                  stage_valid;
  logic [7:0]            stage_byte;
  tkts_pkg::dec_state_t  state;
  tkts_pkg::dec_state_t  state_next;
  tkts_pkg::dec_result_t result;
  logic                  advance;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  tkts_decode u_decode (
    .prefix_mode (prefix_mode),
    .key_byte    (stage_byte),
    .state       (state),
    .state_next  (state_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_mode          <= 1'b0;
      stage_valid          <= 1'b0;
      out_valid            <= 1'b0;
      state.phase          <= tkts_pkg::PH_IDLE;
      state.param          <= 7'd0;
      state.prefix_pending <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= result.emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_write_en) begin
        prefix_mode          <= cfg_write_data;
        state.phase          <= tkts_pkg::PH_IDLE;
        state.param          <= 7'd0;
        state.prefix_pending <= 1'b0;
      end else if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= key_byte;
    end
    if (advance && result.emit) begin
      scan_code  <= result.scan;
      ascii_code <= result.ascii;
    end
  end

endmodule
`default_nettype wire

// File: sv/tkts_checker.sv
`default_nettype none
module tkts_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] scan_code,
  input wire logic [6:0] ascii_code
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scan_code) && $stable(ascii_code))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // every key that comes out has a real scan code
  a_scan_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> scan_code != 8'd0)
    else $error("zero scan code delivered");

  // with nothing waiting on the output the input side never stalls
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind terminal_key_to_scancode_core tkts_checker u_tkts_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .scan_code  (scan_code),
  .ascii_code (ascii_code)
);
`default_nettype wire

// File: bench/terminal_key_to_scancode_core_test.sv
module terminal_key_to_scancode_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic       cfg_write_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] key_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] scan_code;
  logic [6:0] ascii_code;

  terminal_key_to_scancode_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .key_byte       (key_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .scan_code      (scan_code),
    .ascii_code     (ascii_code)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [7:0]            key_queue [$];
  tkts_pkg::dec_result_t pairs_due [$];
  int                    keys_sent = 0;
  int                    err_count = 0;
  int                    stall_cycles = 0;
  logic                  in_taken = 1'b0;
  logic                  no_idle = 1'b0;
  logic                  hold_off_req = 1'b0;
  logic                  hold_taken = 1'b0;
  int                    hold_cnt = 0;

  // decoder state as the block should hold it
  logic             kb_console;
  tkts_pkg::phase_t kb_phase;
  logic [6:0]       kb_param;
  logic             kb_pending;

  function automatic tkts_pkg::dec_result_t plain_pair(logic [7:0] b);
    tkts_pkg::dec_result_t r;
    r = '0;
    if (!b[7] && tkts_pkg::SCAN_ROM[b[6:0]] != 8'h00) begin
      r.emit  = 1'b1;
      r.scan  = tkts_pkg::SCAN_ROM[b[6:0]];
      r.ascii = b[6:0];
    end
    return r;
  endfunction

  function automatic tkts_pkg::dec_result_t predict_pair(logic [7:0] b);
    tkts_pkg::dec_result_t r;
    logic                  done;
    logic                  digit;
    int                    v;
    r = '0;
    done = 1'b0;
    digit = (b >= tkts_pkg::KEY_0) && (b <= tkts_pkg::KEY_9);
    if (kb_console) begin
      if (kb_pending) begin
        kb_pending = 1'b0;
        if (b != tkts_pkg::KEY_NUL) begin
          r.emit = 1'b1;
          r.scan = b;
        end
      end else if (b == tkts_pkg::KEY_PREFIX || b == tkts_pkg::KEY_NUL) begin
        kb_pending = 1'b1;
      end else begin
        r = plain_pair(b);
      end
      return r;
    end
    case (kb_phase)
      tkts_pkg::PH_ESC: begin
        if (b == tkts_pkg::KEY_BRACKET) begin
          kb_phase = tkts_pkg::PH_BRACKET;
          done = 1'b1;
        end else if (b == tkts_pkg::KEY_O) begin
          kb_phase = tkts_pkg::PH_ESC_O;
          done = 1'b1;
        end
      end
      tkts_pkg::PH_BRACKET: begin
        if (b >= tkts_pkg::KEY_A && b <= tkts_pkg::KEY_D) begin
          kb_phase = tkts_pkg::PH_IDLE;
          r.emit = 1'b1;
          case (b[1:0])
            2'd1:    r.scan = tkts_pkg::SCAN_UP;
            2'd2:    r.scan = tkts_pkg::SCAN_DOWN;
            2'd3:    r.scan = tkts_pkg::SCAN_RIGHT;
            default: r.scan = tkts_pkg::SCAN_LEFT;
          endcase
          done = 1'b1;
        end else if (digit) begin
          kb_phase = tkts_pkg::PH_DIGITS;
          kb_param = 7'(b - tkts_pkg::KEY_0);
          done = 1'b1;
        end
      end
      tkts_pkg::PH_ESC_O: begin
        if (b == tkts_pkg::KEY_P) begin
          kb_phase = tkts_pkg::PH_IDLE;
          done = 1'b1;
        end else if (digit) begin
          kb_phase = tkts_pkg::PH_DIGITS;
          kb_param = 7'(b - tkts_pkg::KEY_0);
          done = 1'b1;
        end
      end
      tkts_pkg::PH_DIGITS: begin
        if (digit) begin
          v = kb_param * 10 + (b - tkts_pkg::KEY_0);
          kb_param = (v > tkts_pkg::PARAM_MAX) ? tkts_pkg::PARAM_MAX : 7'(v);
          done = 1'b1;
        end else if (b == tkts_pkg::KEY_TILDE) begin
          kb_phase = tkts_pkg::PH_IDLE;
          v = kb_param;
          if (v >= 11 && v <= 15) begin
            r.emit = 1'b1;
            r.scan = tkts_pkg::FKEY_BASE_LO + 8'(v - 11);
          end else if (v >= 17 && v <= 21) begin
            r.emit = 1'b1;
            r.scan = tkts_pkg::FKEY_BASE_MID + 8'(v - 17);
          end else if (v >= 23 && v <= 24) begin
            r.emit = 1'b1;
            r.scan = tkts_pkg::FKEY_BASE_HI + 8'(v - 23);
          end
          done = 1'b1;
        end
      end
      default: ;
    endcase
    if (!done) begin
      if (b == tkts_pkg::KEY_ESC) begin
        kb_phase = tkts_pkg::PH_ESC;
        kb_param = 7'd0;
      end else begin
        kb_phase = tkts_pkg::PH_IDLE;
        r = plain_pair(b);
      end
    end
    return r;
  endfunction

  // key byte driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (key_queue.size() != 0 && (no_idle || $urandom_range(99) >= 6)) begin
        in_valid <= 1'b1;
        key_byte <= key_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_off_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin : monitor
    tkts_pkg::dec_result_t due;
    tkts_pkg::dec_result_t got;
    if (rst) begin
      kb_console = 1'b0;
      kb_phase = tkts_pkg::PH_IDLE;
      kb_param = 7'd0;
      kb_pending = 1'b0;
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (pairs_due.size() == 0) begin
          $display("%0t: unexpected result scan %h ascii %h", $time, scan_code, ascii_code);
          err_count++;
        end else begin
          due = pairs_due.pop_front();
          if (scan_code !== due.scan) begin
            $display("%0t: scan_code mismatch expected %h actual %h",
                     $time, due.scan, scan_code);
            err_count++;
          end
          if (ascii_code !== due.ascii) begin
            $display("%0t: ascii_code mismatch expected %h actual %h",
                     $time, due.ascii, ascii_code);
            err_count++;
          end
        end
      end
      if (cfg_write_en) begin
        kb_console = cfg_write_data;
        kb_phase = tkts_pkg::PH_IDLE;
        kb_param = 7'd0;
        kb_pending = 1'b0;
      end
      if (in_valid && in_ready) begin
        got = predict_pair(key_byte);
        if (got.emit)
          pairs_due.push_back(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_key(logic [7:0] b);
    key_queue.push_back(b);
    keys_sent++;
  endtask

  task automatic drain();
    forever begin
      @(posedge clk);
      #1;
      if (key_queue.size() == 0 && !in_valid && pairs_due.size() == 0)
        break;
    end
  endtask

  // parser may still be busy on a byte that yields nothing
  task automatic write_mode(logic m);
    drain();
    repeat (8) @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= m;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic queue_terminal_keys(int count);
    int    stop;
    int    kind;
    int    v;
    string s;
    stop = keys_sent + count;
    while (keys_sent < stop) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        send_key(tkts_pkg::KEY_ESC);
        send_key(tkts_pkg::KEY_BRACKET);
        send_key(tkts_pkg::KEY_A + 8'($urandom_range(3)));
      end else if (kind < 22) begin
        send_key(tkts_pkg::KEY_ESC);
        send_key(tkts_pkg::KEY_O);
        send_key(tkts_pkg::KEY_P);
      end else if (kind < 40) begin
        send_key(tkts_pkg::KEY_ESC);
        send_key($urandom_range(1) ? tkts_pkg::KEY_BRACKET : tkts_pkg::KEY_O);
        if ($urandom_range(9) < 7) begin
          v = $urandom_range(11);
          v = (v < 5) ? 11 + v : (v < 10) ? 12 + v : 13 + v;
        end else begin
          v = $urandom_range(1999);
        end
        if ($urandom_range(9) == 0)
          send_key(tkts_pkg::KEY_0);
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
          send_key(s[i]);
        send_key(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : tkts_pkg::KEY_TILDE);
      end else if (kind < 55) begin
        // broken sequence: prefix cut short by some other byte
        send_key(tkts_pkg::KEY_ESC);
        v = $urandom_range(2);
        if (v != 0)
          send_key((v == 1 || $urandom_range(1)) ? tkts_pkg::KEY_BRACKET : tkts_pkg::KEY_O);
        if (v == 2)
          send_key(tkts_pkg::KEY_0 + 8'($urandom_range(9)));
        send_key(8'($urandom_range(255)));
      end else if (kind < 85) begin
        send_key(8'($urandom_range(127)));
      end else begin
        send_key(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic queue_console_keys(int count);
    int stop;
    stop = keys_sent + count;
    while (keys_sent < stop) begin
      if ($urandom_range(99) < 40) begin
        send_key($urandom_range(1) ? tkts_pkg::KEY_PREFIX : tkts_pkg::KEY_NUL);
        send_key(($urandom_range(9) == 0) ? tkts_pkg::KEY_NUL : 8'($urandom_range(255)));
      end else begin
        send_key(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    write_mode(1'b0);
    send_key(tkts_pkg::KEY_ESC); send_key(tkts_pkg::KEY_BRACKET); send_key(tkts_pkg::KEY_A);
    send_key(tkts_pkg::KEY_ESC); send_key(tkts_pkg::KEY_O); send_key(tkts_pkg::KEY_P);
    send_key(tkts_pkg::KEY_ESC); send_key(tkts_pkg::KEY_BRACKET);
    send_key(tkts_pkg::KEY_0 + 8'd2);
    send_key(tkts_pkg::KEY_0 + 8'd4); send_key(tkts_pkg::KEY_TILDE);
    // escape restarts, then escape-O with a letter decodes the letter plainly
    send_key(tkts_pkg::KEY_ESC); send_key(tkts_pkg::KEY_ESC);
    send_key(tkts_pkg::KEY_O); send_key(tkts_pkg::KEY_A);
    // parameter saturates and gives nothing
    send_key(tkts_pkg::KEY_ESC); send_key(tkts_pkg::KEY_BRACKET);
    send_key(tkts_pkg::KEY_9); send_key(tkts_pkg::KEY_9);
    send_key(tkts_pkg::KEY_9); send_key(tkts_pkg::KEY_TILDE);
    send_key(tkts_pkg::KEY_ESC); send_key(8'h71);
    send_key(8'hff); send_key(8'h00); send_key(8'h7f);

    write_mode(1'b1);
    send_key(tkts_pkg::KEY_PREFIX); send_key(8'hff);
    send_key(tkts_pkg::KEY_NUL); send_key(tkts_pkg::KEY_NUL);
    send_key(tkts_pkg::KEY_NUL); send_key(tkts_pkg::KEY_PREFIX);
    send_key(8'h61);

    write_mode(1'b0);
    hold_off_req = 1'b1;
    queue_terminal_keys(500);

    write_mode(1'b1);
    queue_console_keys(300);

    write_mode(1'b0);
    no_idle = 1'b1;
    queue_terminal_keys(500);
    drain();
    no_idle = 1'b0;

    write_mode(1'b1);
    queue_console_keys(250);

    write_mode(1'b0);
    queue_terminal_keys(350);

    drain();
    repeat (12) @(negedge clk);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
